// File: hdl/assert_macros.svh
// Assertion macros for the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/rmsn_pkg.sv
// Types, constants and codes shared by the RMS normalizer modules.
package rmsn_pkg;

  localparam int unsigned MAX_LEN_DEF = 1024;

  localparam int unsigned VLEN_W      = 11;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned PADDR_W     = 3;

  localparam logic [VLEN_W-1:0] VLEN_RESET = 11'd1024;
  localparam logic [31:0]       EPS_RESET  = 32'd42950;

  // Register indexes, taken from paddr[2].
  localparam logic REG_VECTOR_LENGTH = 1'b0;
  localparam logic REG_EPSILON       = 1'b1;

  // Input commands.
  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_SCALE = 1'b1;

  // Queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = 1;
  localparam int unsigned QUEUE_CW    = 2;

  // Iteration counts of the reciprocal-root unit.
  localparam int unsigned DIV_STEPS  = 65;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned STEP_W     = 7;

  localparam logic [64:0] RECIP_DIVIDEND = {1'b1, 64'd0};
  localparam logic [63:0] SQRT_BIT_INIT  = {2'b01, 62'd0};
  localparam logic [31:0] ROOT_MAX       = 32'hFFFF_FFFF;
  localparam logic [31:0] POS_LIMIT      = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT      = 32'h8000_0000;

  // One classified input item.
  typedef struct packed {
    logic        scale;
    logic        x_neg;
    logic [31:0] x_mag;
    logic        w_neg;
    logic [31:0] w_mag;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] square_sum;
  } root_req_t;

  typedef struct packed {
    logic        done;
    logic        clip;
    logic [31:0] root;
  } root_rsp_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ACC,
    BK_ROOT,
    BK_MUL_A,
    BK_MUL_HI,
    BK_MUL_LO,
    BK_SAT
  } back_state_t;

  typedef enum logic [2:0] {
    RT_IDLE,
    RT_DIV_MEAN,
    RT_EPS,
    RT_DIV_RECIP,
    RT_SQRT,
    RT_DONE
  } root_state_t;

endpackage

// File: hdl/rmsn_front.sv
// Front end: accepts input transactions, classifies them and queues them for the back end.
module rmsn_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic signed [31:0]  in_sample,
  input  logic signed [31:0]  in_gain,
  output logic                q_valid,
  input  logic                q_pop,
  output rmsn_pkg::item_t     q_item
);

  rmsn_pkg::item_t                      cls_item;
  rmsn_pkg::item_t                      mem_r [rmsn_pkg::QUEUE_DEPTH];
  logic [rmsn_pkg::QUEUE_AW-1:0]        wr_ptr_r;
  logic [rmsn_pkg::QUEUE_AW-1:0]        rd_ptr_r;
  logic [rmsn_pkg::QUEUE_CW-1:0]        count_r;
  logic [rmsn_pkg::QUEUE_CW-1:0]        count_nxt;
  logic                                 push;
  logic                                 pop;

  // Split both operands into sign and magnitude; the most negative value
  // maps to a magnitude of 2^31, which still fits in 32 unsigned bits.
  always_comb begin
    cls_item.scale = (in_cmd == rmsn_pkg::CMD_SCALE);
    cls_item.x_neg = in_sample[31];
    cls_item.x_mag = in_sample[31] ? (~unsigned'(in_sample) + 32'd1) : unsigned'(in_sample);
    cls_item.w_neg = in_gain[31];
    cls_item.w_mag = in_gain[31] ? (~unsigned'(in_gain) + 32'd1) : unsigned'(in_gain);
  end

  assign in_ready = (count_r != rmsn_pkg::QUEUE_CW'(rmsn_pkg::QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + rmsn_pkg::QUEUE_CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - rmsn_pkg::QUEUE_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + rmsn_pkg::QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + rmsn_pkg::QUEUE_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls_item;
    end
  end

endmodule

// File: hdl/rmsn_root.sv
// Reciprocal square root of the mean square: two restoring divisions and a bit-pair square root.
module rmsn_root #(
  parameter int unsigned MAX_LEN = rmsn_pkg::MAX_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rmsn_pkg::root_req_t              req,
  input  logic [$clog2(MAX_LEN+1)-1:0]     len,
  input  logic [31:0]                      epsilon,
  output rmsn_pkg::root_rsp_t              rsp
);

  rmsn_pkg::root_state_t             state_r;
  rmsn_pkg::root_state_t             state_nxt;
  logic [rmsn_pkg::STEP_W-1:0]       step_r;
  logic [64:0]                       dvd_r;
  logic [63:0]                       dvs_r;
  logic [63:0]                       rem_r;
  logic [63:0]                       v_r;
  logic [63:0]                       res_r;
  logic [63:0]                       bit_r;
  logic [31:0]                       root_r;
  logic                              clip_r;

  logic [64:0]                       rem_sh;
  logic [64:0]                       rem_diff;
  logic                              div_ge;
  logic [64:0]                       mean_sum;
  logic [63:0]                       mean;
  logic                              mean_tiny;
  logic [63:0]                       sq_try;
  logic                              sq_ge;
  logic [63:0]                       res_nxt;
  logic                              step_last;

  // One restoring division step: the quotient shifts into the dividend.
  always_comb begin
    rem_sh   = {rem_r, dvd_r[64]};
    rem_diff = rem_sh - {1'b0, dvs_r};
    div_ge   = (rem_sh >= {1'b0, dvs_r});
  end

  // Mean plus epsilon saturates at all ones.
  always_comb begin
    mean_sum  = {1'b0, dvd_r[63:0]} + {33'd0, epsilon};
    mean      = mean_sum[64] ? '1 : mean_sum[63:0];
    mean_tiny = (mean <= 64'd1);
  end

  always_comb begin
    sq_try  = res_r + bit_r;
    sq_ge   = (v_r >= sq_try);
    res_nxt = sq_ge ? ((res_r >> 1) + bit_r) : (res_r >> 1);
  end

  assign step_last = (step_r == '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rmsn_pkg::RT_IDLE: begin
        if (req.start) begin
          state_nxt = rmsn_pkg::RT_DIV_MEAN;
        end
      end
      rmsn_pkg::RT_DIV_MEAN: begin
        if (step_last) begin
          state_nxt = rmsn_pkg::RT_EPS;
        end
      end
      rmsn_pkg::RT_EPS: begin
        state_nxt = mean_tiny ? rmsn_pkg::RT_DONE : rmsn_pkg::RT_DIV_RECIP;
      end
      rmsn_pkg::RT_DIV_RECIP: begin
        if (step_last) begin
          state_nxt = rmsn_pkg::RT_SQRT;
        end
      end
      rmsn_pkg::RT_SQRT: begin
        if (step_last) begin
          state_nxt = rmsn_pkg::RT_DONE;
        end
      end
      rmsn_pkg::RT_DONE: begin
        state_nxt = rmsn_pkg::RT_IDLE;
      end
      default: begin
        state_nxt = rmsn_pkg::RT_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp.done = (state_r == rmsn_pkg::RT_DONE);
    rsp.clip = clip_r;
    rsp.root = root_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rmsn_pkg::RT_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      rmsn_pkg::RT_IDLE: begin
        if (req.start) begin
          dvd_r  <= {1'b0, req.square_sum};
          dvs_r  <= 64'(len);
          rem_r  <= '0;
          clip_r <= 1'b0;
          step_r <= rmsn_pkg::STEP_W'(rmsn_pkg::DIV_STEPS - 1);
        end
      end
      rmsn_pkg::RT_DIV_MEAN: begin
        dvd_r  <= {dvd_r[63:0], div_ge};
        rem_r  <= div_ge ? rem_diff[63:0] : rem_sh[63:0];
        step_r <= step_r - rmsn_pkg::STEP_W'(1);
      end
      rmsn_pkg::RT_EPS: begin
        if (mean_sum[64]) begin
          clip_r <= 1'b1;
        end
        if (mean_tiny) begin
          root_r <= rmsn_pkg::ROOT_MAX;
        end else begin
          // floor(2^64 / m) is the reciprocal of the mean in Q0.64.
          dvd_r  <= rmsn_pkg::RECIP_DIVIDEND;
          dvs_r  <= mean;
          rem_r  <= '0;
          step_r <= rmsn_pkg::STEP_W'(rmsn_pkg::DIV_STEPS - 1);
        end
      end
      rmsn_pkg::RT_DIV_RECIP: begin
        dvd_r  <= {dvd_r[63:0], div_ge};
        rem_r  <= div_ge ? rem_diff[63:0] : rem_sh[63:0];
        step_r <= step_last ? rmsn_pkg::STEP_W'(rmsn_pkg::SQRT_STEPS - 1)
                            : step_r - rmsn_pkg::STEP_W'(1);
        if (step_last) begin
          v_r    <= {dvd_r[62:0], div_ge};
          res_r  <= '0;
          bit_r  <= rmsn_pkg::SQRT_BIT_INIT;
        end
      end
      rmsn_pkg::RT_SQRT: begin
        if (sq_ge) begin
          v_r <= v_r - sq_try;
        end
        res_r  <= res_nxt;
        bit_r  <= bit_r >> 2;
        step_r <= step_r - rmsn_pkg::STEP_W'(1);
        if (step_last) begin
          root_r <= res_nxt[31:0];
        end
      end
      rmsn_pkg::RT_DONE: begin
        root_r <= root_r;
      end
      default: begin
        step_r <= '0;
      end
    endcase
  end

endmodule

// File: hdl/rmsn_back.sv
// Back end: sum of squares, vector state, scale multiplies and the output register.
module rmsn_back #(
  parameter int unsigned MAX_LEN = rmsn_pkg::MAX_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  output logic                             q_pop,
  input  rmsn_pkg::item_t                  q_item,
  input  logic [$clog2(MAX_LEN+1)-1:0]     eff_len,
  output rmsn_pkg::root_req_t              root_req,
  input  rmsn_pkg::root_rsp_t              root_rsp,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [31:0]               out_normalized,
  output logic                             out_last,
  output logic                             out_saturated
);

  localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);

  rmsn_pkg::back_state_t   state_r;
  rmsn_pkg::back_state_t   state_nxt;
  rmsn_pkg::item_t         cur_r;

  logic [63:0]             square_sum_r;
  logic [LEN_W-1:0]        count_r;
  logic [31:0]             inv_root_r;
  logic                    in_scale_r;
  logic                    sum_clipped_r;

  logic [63:0]             prod_r;
  logic [31:0]             a_lo_r;
  logic [63:0]             hi_r;

  logic                    out_valid_r;
  logic [31:0]             out_norm_r;
  logic                    out_last_r;
  logic                    out_sat_r;

  logic [31:0]             mul_a;
  logic [31:0]             mul_b;
  logic [63:0]             mul_p;
  logic [64:0]             acc_sum;
  logic [63:0]             q_mag;
  logic                    res_neg;
  logic                    res_clip;
  logic [31:0]             res_mag;
  logic [31:0]             res_val;
  logic [LEN_W-1:0]        cnt_inc;
  logic                    res_last;
  logic                    out_free;
  logic                    out_load;
  logic                    root_start;

  // One shared 32x32 multiplier; the operands follow the sequencer state.
  always_comb begin
    unique case (state_r)
      rmsn_pkg::BK_IDLE: begin
        mul_a = q_item.x_mag;
        mul_b = q_item.x_mag;
      end
      rmsn_pkg::BK_MUL_A: begin
        mul_a = cur_r.x_mag;
        mul_b = inv_root_r;
      end
      rmsn_pkg::BK_MUL_HI: begin
        mul_a = {1'b0, prod_r[62:32]};
        mul_b = cur_r.w_mag;
      end
      rmsn_pkg::BK_MUL_LO: begin
        mul_a = a_lo_r;
        mul_b = cur_r.w_mag;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = 64'(mul_a) * 64'(mul_b);
  assign acc_sum = {1'b0, square_sum_r} + {1'b0, prod_r};

  // Product magnitude in Q16.16, then clip to the signed output range.
  always_comb begin
    q_mag   = hi_r + {32'd0, prod_r[63:32]};
    res_neg = cur_r.x_neg ^ cur_r.w_neg;
    if (!res_neg) begin
      res_clip = (q_mag[63:31] != '0);
      res_mag  = res_clip ? rmsn_pkg::POS_LIMIT : q_mag[31:0];
      res_val  = res_mag;
    end else begin
      res_clip = (q_mag > {32'd0, rmsn_pkg::NEG_LIMIT});
      res_mag  = res_clip ? rmsn_pkg::NEG_LIMIT : q_mag[31:0];
      res_val  = ~res_mag + 32'd1;
    end
    cnt_inc  = count_r + LEN_W'(1);
    res_last = (cnt_inc >= eff_len);
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rmsn_pkg::BK_IDLE: begin
        if (q_valid) begin
          if (!q_item.scale) begin
            state_nxt = rmsn_pkg::BK_ACC;
          end else if (in_scale_r) begin
            state_nxt = rmsn_pkg::BK_MUL_A;
          end else begin
            state_nxt = rmsn_pkg::BK_ROOT;
          end
        end
      end
      rmsn_pkg::BK_ACC: begin
        state_nxt = rmsn_pkg::BK_IDLE;
      end
      rmsn_pkg::BK_ROOT: begin
        if (root_rsp.done) begin
          state_nxt = rmsn_pkg::BK_MUL_A;
        end
      end
      rmsn_pkg::BK_MUL_A: begin
        state_nxt = rmsn_pkg::BK_MUL_HI;
      end
      rmsn_pkg::BK_MUL_HI: begin
        state_nxt = rmsn_pkg::BK_MUL_LO;
      end
      rmsn_pkg::BK_MUL_LO: begin
        state_nxt = rmsn_pkg::BK_SAT;
      end
      rmsn_pkg::BK_SAT: begin
        if (out_free) begin
          state_nxt = rmsn_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = rmsn_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop      = (state_r == rmsn_pkg::BK_IDLE) && q_valid;
    root_start = q_pop && q_item.scale && !in_scale_r;
    out_load   = (state_r == rmsn_pkg::BK_SAT) && out_free;
  end

  assign root_req.start      = root_start;
  assign root_req.square_sum = square_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= rmsn_pkg::BK_IDLE;
      square_sum_r  <= '0;
      count_r       <= '0;
      inv_root_r    <= '0;
      in_scale_r    <= 1'b0;
      sum_clipped_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      // An accumulate transaction during the scale pass starts a new vector.
      if (q_pop && !q_item.scale && in_scale_r) begin
        square_sum_r  <= '0;
        count_r       <= '0;
        inv_root_r    <= '0;
        in_scale_r    <= 1'b0;
        sum_clipped_r <= 1'b0;
      end

      if (state_r == rmsn_pkg::BK_ACC) begin
        if (acc_sum[64]) begin
          square_sum_r  <= '1;
          sum_clipped_r <= 1'b1;
        end else begin
          square_sum_r <= acc_sum[63:0];
        end
      end

      if ((state_r == rmsn_pkg::BK_ROOT) && root_rsp.done) begin
        inv_root_r    <= root_rsp.root;
        sum_clipped_r <= sum_clipped_r | root_rsp.clip;
        in_scale_r    <= 1'b1;
        count_r       <= '0;
      end

      if (out_load) begin
        if (res_last) begin
          square_sum_r  <= '0;
          count_r       <= '0;
          inv_root_r    <= '0;
          in_scale_r    <= 1'b0;
          sum_clipped_r <= 1'b0;
        end else begin
          count_r <= cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_item;
    end
    if (state_r != rmsn_pkg::BK_SAT) begin
      prod_r <= mul_p;
    end
    if (state_r == rmsn_pkg::BK_MUL_HI) begin
      a_lo_r <= prod_r[31:0];
    end
    if (state_r == rmsn_pkg::BK_MUL_LO) begin
      hi_r <= prod_r;
    end
    if (out_load) begin
      out_norm_r <= res_val;
      out_last_r <= res_last;
      out_sat_r  <= res_clip | sum_clipped_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_normalized = signed'(out_norm_r);
  assign out_last       = out_last_r;
  assign out_saturated  = out_sat_r;

endmodule

// File: hdl/rms_normalizer_core.sv
// Top level of the streamed RMS normalizer with its configuration registers.
//
// Input channel (in_valid/in_ready): in_cmd selects an accumulate element (adds
// sample squared to the vector's sum) or a scale element (emits
// sample * inverse root * gain). Result channel (out_valid/out_ready) carries one
// transaction per scale element; out_last marks the vector's final element.
// The APB port writes vector_length at address 0 and epsilon at address 4.
//
// A two-entry queue decouples the front from the back. The back, with its single
// shared 32x32 multiplier, pops an element only in IDLE and steps through ACC for
// an accumulate element or MUL_A, MUL_HI, MUL_LO and SAT for a scale element. The
// first scale element of a vector also waits for the reciprocal root: two 65-step
// restoring divisions, an epsilon state, a 32-step square root and a done state,
// with the second division and the square root skipped when mean plus epsilon is
// 0 or 1. SAT waits until the output register is free, then loads it for out_valid.
//
// Synchronous reset clears the vector state, the queue and out_valid
// and loads vector_length 1024 and epsilon 42950. When the receiver stalls, the
// result holds in the output register, the back waits and the queue fills
// before in_ready drops.
module rms_normalizer_core #(
  parameter int unsigned MAX_LEN = rmsn_pkg::MAX_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_cmd,
  input  logic signed [31:0]                in_sample,
  input  logic signed [31:0]                in_gain,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [31:0]                out_normalized,
  output logic                              out_last,
  output logic                              out_saturated,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rmsn_pkg::PADDR_W-1:0]      paddr,
  input  logic [rmsn_pkg::DATA_W-1:0]       pwdata,
  output logic [rmsn_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);
  localparam int unsigned CMP_W = (LEN_W > rmsn_pkg::VLEN_W) ? LEN_W : rmsn_pkg::VLEN_W;

  logic [rmsn_pkg::VLEN_W-1:0]  vlen_r;
  logic [31:0]                  eps_r;
  logic                         reg_idx;
  logic                         cfg_wr;
  logic [CMP_W-1:0]             vlen_cmp;
  logic [CMP_W-1:0]             eff_cmp;
  logic [LEN_W-1:0]             eff_len;

  logic                         q_valid;
  logic                         q_pop;
  rmsn_pkg::item_t              q_item;
  rmsn_pkg::root_req_t          root_req;
  rmsn_pkg::root_rsp_t          root_rsp;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlen_r <= rmsn_pkg::VLEN_RESET;
      eps_r  <= rmsn_pkg::EPS_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        rmsn_pkg::REG_VECTOR_LENGTH: vlen_r <= pwdata[rmsn_pkg::VLEN_W-1:0];
        rmsn_pkg::REG_EPSILON:       eps_r  <= pwdata;
        default:                     eps_r  <= eps_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rmsn_pkg::REG_VECTOR_LENGTH: prdata = rmsn_pkg::DATA_W'(vlen_r);
      rmsn_pkg::REG_EPSILON:       prdata = eps_r;
      default:                     prdata = '0;
    endcase
  end

  // A length of zero acts as one; lengths above MAX_LEN clip to it.
  always_comb begin
    vlen_cmp = CMP_W'(vlen_r);
    if (vlen_cmp == '0) begin
      eff_cmp = CMP_W'(1);
    end else if (vlen_cmp > CMP_W'(MAX_LEN)) begin
      eff_cmp = CMP_W'(MAX_LEN);
    end else begin
      eff_cmp = vlen_cmp;
    end
    eff_len = eff_cmp[LEN_W-1:0];
  end

  rmsn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .in_sample (in_sample),
    .in_gain   (in_gain),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  rmsn_root #(
    .MAX_LEN (MAX_LEN)
  ) u_root (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (root_req),
    .len     (eff_len),
    .epsilon (eps_r),
    .rsp     (root_rsp)
  );

  rmsn_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_item         (q_item),
    .eff_len        (eff_len),
    .root_req       (root_req),
    .root_rsp       (root_rsp),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_normalized (out_normalized),
    .out_last       (out_last),
    .out_saturated  (out_saturated)
  );

endmodule

// File: hdl/rmsn_checker.sv
// Port-level checker for the RMS normalizer, bound to the top level.
`include "assert_macros.svh"

module rmsn_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_cmd,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [31:0]             out_normalized,
  input logic                           out_last,
  input logic                           out_saturated,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [rmsn_pkg::PADDR_W-1:0]   paddr,
  input logic [rmsn_pkg::DATA_W-1:0]    pwdata,
  input logic [rmsn_pkg::DATA_W-1:0]    prdata
);

  logic [3:0] pend_r;
  logic [3:0] pend_nxt;
  logic       scale_in;
  logic       res_out;

  // Scale transactions accepted but not yet delivered as results.
  assign scale_in = in_valid && in_ready && (in_cmd == rmsn_pkg::CMD_SCALE);
  assign res_out  = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (scale_in && !res_out) begin
      pend_nxt = pend_r + 4'd1;
    end else if (res_out && !scale_in) begin
      pend_nxt = pend_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `ASSERT_CLK(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_normalized) && $stable(out_last) && $stable(out_saturated)), "result changed while stalled")

  `ASSERT_CLK_NR(a_reset_idle, clk, !rst_n |=> !out_valid, "result valid right after reset")

  `ASSERT_CLK(a_no_orphan, clk, rst_n, out_valid |-> (pend_r != 4'd0), "result without a pending scale transaction")

  `ASSERT_CLK(a_eps_readback, clk, rst_n, (psel && penable && pwrite && paddr[2]) |=> (!paddr[2] || (prdata == $past(pwdata))), "epsilon readback differs from written value")

endmodule

bind rms_normalizer_core rmsn_checker u_rmsn_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_cmd         (in_cmd),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_normalized (out_normalized),
  .out_last       (out_last),
  .out_saturated  (out_saturated),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .paddr          (paddr),
  .pwdata         (pwdata),
  .prdata         (prdata)
);
